>>> hdl/cikht_pkg.sv
package cikht_pkg;

    // Default sizing
    localparam int TABLE_SIZE_DEF    = 64;
    localparam int MAX_KEY_BYTES_DEF = 16;

    // Fixed field widths
    localparam int KEY_W      = 64;
    localparam int KEY_LEN_W  = 5;
    localparam int HANDLE_W   = 32;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = 6;

    // djb2 constants
    localparam logic [63:0] HASH_START = 64'd5381;
    localparam int          HASH_SHIFT = 5;

    // Command codes (any other code is taken as a fetch)
    localparam logic [CMD_W-1:0] CMD_STORE_NORMAL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STORE_META   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FETCH        = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    // One table entry as held in the slot memory
    typedef struct packed {
        logic                 used;
        logic [KEY_W-1:0]     key_low;
        logic [KEY_W-1:0]     key_high;
        logic [KEY_LEN_W-1:0] key_len;
        logic [HANDLE_W-1:0]  command;
        logic [HANDLE_W-1:0]  format;
        logic                 is_meta;
    } entry_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_RESULT
    } ctrl_state_t;

    // Hash unit states
    typedef enum logic [1:0] {
        HS_IDLE,
        HS_ACC,
        HS_MOD
    } hash_state_t;

endpackage

>>> hdl/cikht_ram.sv
module cikht_ram #(
    parameter int DEPTH = cikht_pkg::TABLE_SIZE_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  cikht_pkg::entry_t        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output cikht_pkg::entry_t        rd_data
);

    cikht_pkg::entry_t mem [DEPTH];
    cikht_pkg::entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/cikht_hash.sv
module cikht_hash #(
    parameter int TABLE_SIZE = cikht_pkg::TABLE_SIZE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [2*cikht_pkg::KEY_W-1:0]       key,
    input  logic [cikht_pkg::KEY_LEN_W-1:0]     key_len,
    output logic                                done,
    output logic [$clog2(TABLE_SIZE)-1:0]       home
);

    localparam int  IDX_W   = $clog2(TABLE_SIZE);
    localparam int  R_W     = IDX_W + 1;
    localparam bit  IS_POW2 = (TABLE_SIZE == (1 << IDX_W));
    localparam logic [R_W-1:0] MODULUS = R_W'(TABLE_SIZE);

    cikht_pkg::hash_state_t hs_reg, hs_next;
    logic [63:0]                       h_reg, h_next;
    logic [cikht_pkg::KEY_LEN_W-1:0]   pos_reg, pos_next;
    logic [R_W-1:0]                    r_reg, r_next;
    logic [2:0]                        chunk_reg, chunk_next;
    logic [IDX_W-1:0]                  home_reg, home_next;
    logic                              done_reg, done_next;
    logic [7:0]                        cur_byte;
    logic [R_W-1:0]                    r_step;

    // Restoring remainder over eight hash bits, most significant first
    function automatic logic [R_W-1:0] mod_byte(input logic [R_W-1:0] r_in,
                                               input logic [7:0] bits);
        logic [R_W-1:0] r;
        r = r_in;
        for (int k = 7; k >= 0; k--)
        begin
            r = {r[R_W-2:0], bits[k]};
            if (r >= MODULUS)
            begin
                r = r - MODULUS;
            end
        end
        return r;
    endfunction

    assign cur_byte = key[{pos_reg[3:0], 3'b000} +: 8];
    assign r_step   = mod_byte(r_reg, h_reg[63:56]);

    // One key byte per cycle, then 8 remainder bits per cycle for non-pow2 sizes
    always_comb
    begin
        hs_next    = hs_reg;
        h_next     = h_reg;
        pos_next   = pos_reg;
        r_next     = r_reg;
        chunk_next = chunk_reg;
        home_next  = home_reg;
        done_next  = 1'b0;
        case (hs_reg)
            cikht_pkg::HS_IDLE:
            begin
                if (start)
                begin
                    h_next   = cikht_pkg::HASH_START;
                    pos_next = '0;
                    hs_next  = cikht_pkg::HS_ACC;
                end
            end
            cikht_pkg::HS_ACC:
            begin
                if (pos_reg < key_len)
                begin
                    h_next   = (h_reg << cikht_pkg::HASH_SHIFT) + h_reg + {56'd0, cur_byte};
                    pos_next = pos_reg + 1'b1;
                end
                else if (IS_POW2)
                begin
                    home_next = h_reg[IDX_W-1:0];
                    done_next = 1'b1;
                    hs_next   = cikht_pkg::HS_IDLE;
                end
                else
                begin
                    r_next     = '0;
                    chunk_next = '0;
                    hs_next    = cikht_pkg::HS_MOD;
                end
            end
            cikht_pkg::HS_MOD:
            begin
                r_next     = r_step;
                h_next     = h_reg << 8;
                chunk_next = chunk_reg + 1'b1;
                if (chunk_reg == 3'd7)
                begin
                    home_next = r_step[IDX_W-1:0];
                    done_next = 1'b1;
                    hs_next   = cikht_pkg::HS_IDLE;
                end
            end
            default:
            begin
                hs_next = cikht_pkg::HS_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hs_reg   <= cikht_pkg::HS_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            hs_reg   <= hs_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        h_reg     <= h_next;
        pos_reg   <= pos_next;
        r_reg     <= r_next;
        chunk_reg <= chunk_next;
        home_reg  <= home_next;
    end

    assign done = done_reg;
    assign home = home_reg;

endmodule

>>> hdl/case_insensitive_keyed_hash_table.sv
// Open-addressed name table with case-folded djb2 hashing and linear probing.
// A store (normal or meta) writes the name and its handles into the first free
// slot from the home slot on; a fetch walks from the home slot until a name of
// equal length matches without regard to ASCII case, an empty slot is met, or
// every slot has been visited. One transaction is worked at a time: the hash
// unit folds in one key byte per cycle and the probe loop reads one slot per
// cycle from the slot memory, which has separate read and write ports. When
// TABLE_SIZE is not a power of two the home slot is then reduced by restoring
// remainder logic over the 64-bit hash. After reset a clearing pass marks
// every slot free; no item is taken until it is done. A finished result waits
// in the output register while the next item is taken in.
module case_insensitive_keyed_hash_table #(
    parameter int TABLE_SIZE    = cikht_pkg::TABLE_SIZE_DEF,
    parameter int MAX_KEY_BYTES = cikht_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // key_low[63:0], key_high[127:64], key_len[132:128],
    // command_handle[164:133], format_handle[196:165], zero pad[199:197]
    input  logic [199:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // slot[5:0], found_command[37:6], found_format[69:38], found_meta[70],
    // zero pad[71]
    output logic [71:0]  m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    localparam logic [cikht_pkg::KEY_LEN_W-1:0] MAX_LEN =
        cikht_pkg::KEY_LEN_W'(MAX_KEY_BYTES);

    cikht_pkg::ctrl_state_t state_reg, state_next;

    logic [cikht_pkg::CMD_W-1:0]     cmd_reg, cmd_next;
    logic [cikht_pkg::KEY_W-1:0]     key_low_reg, key_low_next;
    logic [cikht_pkg::KEY_W-1:0]     key_high_reg, key_high_next;
    logic [cikht_pkg::KEY_LEN_W-1:0] key_len_reg, key_len_next;
    logic [cikht_pkg::HANDLE_W-1:0]  chandle_reg, chandle_next;
    logic [cikht_pkg::HANDLE_W-1:0]  fhandle_reg, fhandle_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic [IDX_W-1:0]                lap_reg, lap_next;
    logic [IDX_W-1:0]                clr_reg, clr_next;

    logic [cikht_pkg::STATUS_W-1:0]  pend_status_reg, pend_status_next;
    logic [cikht_pkg::SLOT_W-1:0]    pend_slot_reg, pend_slot_next;
    logic [cikht_pkg::HANDLE_W-1:0]  pend_cmd_reg, pend_cmd_next;
    logic [cikht_pkg::HANDLE_W-1:0]  pend_fmt_reg, pend_fmt_next;
    logic                            pend_meta_reg, pend_meta_next;

    logic                            out_valid_reg, out_valid_next;
    logic [cikht_pkg::STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [cikht_pkg::SLOT_W-1:0]    out_slot_reg, out_slot_next;
    logic [cikht_pkg::HANDLE_W-1:0]  out_cmd_reg, out_cmd_next;
    logic [cikht_pkg::HANDLE_W-1:0]  out_fmt_reg, out_fmt_next;
    logic                            out_meta_reg, out_meta_next;

    logic                            accept;
    logic [cikht_pkg::KEY_LEN_W-1:0] in_len;
    logic                            is_store;
    logic                            key_match;
    logic [127:0]                    byte_mask;
    logic                            hash_done;
    logic [IDX_W-1:0]                hash_home;
    logic                            wr_en;
    logic [IDX_W-1:0]                wr_addr;
    cikht_pkg::entry_t               wr_data;
    logic                            rd_en;
    logic [IDX_W-1:0]                rd_addr;
    cikht_pkg::entry_t               rd_data;

    // Lower-case ASCII capitals in each byte of a word
    function automatic logic [63:0] fold_word(input logic [63:0] w);
        logic [63:0] r;
        logic [7:0]  b;
        r = w;
        for (int i = 0; i < 8; i++)
        begin
            b = w[i*8 +: 8];
            if (b >= 8'h41 && b <= 8'h5A)
            begin
                r[i*8 +: 8] = b + 8'h20;
            end
        end
        return r;
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == cikht_pkg::ST_IDLE);
    assign in_len   = (s_tdata[132:128] > MAX_LEN) ? MAX_LEN : s_tdata[132:128];
    assign is_store = (cmd_reg == cikht_pkg::CMD_STORE_NORMAL) ||
                      (cmd_reg == cikht_pkg::CMD_STORE_META);

    // Compare the stored name with the held name over the valid bytes only
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            byte_mask[i*8 +: 8] = (5'(i) < key_len_reg) ? 8'hFF : 8'h00;
        end
        key_match = (rd_data.key_len == key_len_reg) &&
                    ((({rd_data.key_high, rd_data.key_low} ^ {key_high_reg, key_low_reg})
                      & byte_mask) == 128'd0);
    end

    cikht_hash #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_hash (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .key     ({key_high_reg, key_low_reg}),
        .key_len (key_len_reg),
        .done    (hash_done),
        .home    (hash_home)
    );

    cikht_ram #(
        .DEPTH (TABLE_SIZE)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer: clear, take item, hash, probe, hand result over
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        key_low_next     = key_low_reg;
        key_high_next    = key_high_reg;
        key_len_next     = key_len_reg;
        chandle_next     = chandle_reg;
        fhandle_next     = fhandle_reg;
        idx_next         = idx_reg;
        lap_next         = lap_reg;
        clr_next         = clr_reg;
        pend_status_next = pend_status_reg;
        pend_slot_next   = pend_slot_reg;
        pend_cmd_next    = pend_cmd_reg;
        pend_fmt_next    = pend_fmt_reg;
        pend_meta_next   = pend_meta_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_slot_next    = out_slot_reg;
        out_cmd_next     = out_cmd_reg;
        out_fmt_next     = out_fmt_reg;
        out_meta_next    = out_meta_reg;
        wr_en            = 1'b0;
        wr_addr          = idx_reg;
        wr_data          = '0;
        rd_en            = 1'b0;
        rd_addr          = idx_reg;

        case (state_reg)
            cikht_pkg::ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = cikht_pkg::ST_IDLE;
                end
            end
            cikht_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next      = s_tuser;
                    key_low_next  = fold_word(s_tdata[63:0]);
                    key_high_next = fold_word(s_tdata[127:64]);
                    key_len_next  = in_len;
                    chandle_next  = s_tdata[164:133];
                    fhandle_next  = s_tdata[196:165];
                    state_next    = cikht_pkg::ST_HASH;
                end
            end
            cikht_pkg::ST_HASH:
            begin
                if (hash_done)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = hash_home;
                    idx_next   = hash_home;
                    lap_next   = '0;
                    state_next = cikht_pkg::ST_PROBE;
                end
            end
            cikht_pkg::ST_PROBE:
            begin
                pend_status_next = cikht_pkg::STATUS_OK;
                pend_slot_next   = cikht_pkg::SLOT_W'(idx_reg);
                pend_cmd_next    = '0;
                pend_fmt_next    = '0;
                pend_meta_next   = 1'b0;
                if (!rd_data.used)
                begin
                    // Free slot: write a store, end a fetch
                    if (is_store)
                    begin
                        wr_en            = 1'b1;
                        wr_data.used     = 1'b1;
                        wr_data.key_low  = key_low_reg;
                        wr_data.key_high = key_high_reg;
                        wr_data.key_len  = key_len_reg;
                        wr_data.command  = chandle_reg;
                        wr_data.is_meta  = (cmd_reg == cikht_pkg::CMD_STORE_META);
                        wr_data.format   = (cmd_reg == cikht_pkg::CMD_STORE_META) ?
                                           '0 : fhandle_reg;
                    end
                    else
                    begin
                        pend_status_next = cikht_pkg::STATUS_NOT_FOUND;
                        pend_slot_next   = '0;
                    end
                    state_next = cikht_pkg::ST_RESULT;
                end
                else if (!is_store && key_match)
                begin
                    pend_cmd_next  = rd_data.command;
                    pend_fmt_next  = rd_data.is_meta ? '0 : rd_data.format;
                    pend_meta_next = rd_data.is_meta;
                    state_next     = cikht_pkg::ST_RESULT;
                end
                else if (lap_reg == LAST_IDX)
                begin
                    pend_status_next = cikht_pkg::STATUS_FULL;
                    pend_slot_next   = '0;
                    state_next       = cikht_pkg::ST_RESULT;
                end
                else
                begin
                    // Advance to the next slot with wrap
                    idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
                    lap_next = lap_reg + 1'b1;
                    rd_en    = 1'b1;
                    rd_addr  = idx_next;
                end
            end
            cikht_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_slot_next   = pend_slot_reg;
                    out_cmd_next    = pend_cmd_reg;
                    out_fmt_next    = pend_fmt_reg;
                    out_meta_next   = pend_meta_reg;
                    state_next      = cikht_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cikht_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cikht_pkg::ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        key_low_reg     <= key_low_next;
        key_high_reg    <= key_high_next;
        key_len_reg     <= key_len_next;
        chandle_reg     <= chandle_next;
        fhandle_reg     <= fhandle_next;
        idx_reg         <= idx_next;
        lap_reg         <= lap_next;
        pend_status_reg <= pend_status_next;
        pend_slot_reg   <= pend_slot_next;
        pend_cmd_reg    <= pend_cmd_next;
        pend_fmt_reg    <= pend_fmt_next;
        pend_meta_reg   <= pend_meta_next;
        out_status_reg  <= out_status_next;
        out_slot_reg    <= out_slot_next;
        out_cmd_reg     <= out_cmd_next;
        out_fmt_reg     <= out_fmt_next;
        out_meta_reg    <= out_meta_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {1'b0, out_meta_reg, out_fmt_reg, out_cmd_reg, out_slot_reg};

endmodule
